### hw/rtl/slt_pkg.sv
// Shared constants and types for the sorted list table.
`default_nettype none
package slt_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

    // Broadcast from the top to every cell.
    typedef struct packed {
        logic                     ins_en;
        logic                     del_en;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

    // Compare flags a cell hands to its right neighbor.
    typedef struct packed {
        logic valid;
        logic lt;
        logic eq;
    } t_cell_flags;

endpackage
`default_nettype wire

### hw/rtl/slt_req_if.sv
// Request channel of the sorted list table.
`default_nettype none
interface slt_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [slt_pkg::KIND_W-1:0]           kind;
    logic signed [slt_pkg::DATA_W-1:0]    value;

    modport source (output valid, kind, value, input ready);
    modport sink   (input valid, kind, value, output ready);
endinterface
`default_nettype wire

### hw/rtl/slt_rsp_if.sv
// Result channel of the sorted list table.
`default_nettype none
interface slt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [slt_pkg::STATUS_W-1:0]   status;
    logic                           found;
    logic [slt_pkg::POS_W-1:0]      position;
    logic [slt_pkg::COUNT_W-1:0]    entry_count;

    modport source (output valid, status, found, position, entry_count, input ready);
    modport sink   (input valid, status, found, position, entry_count, output ready);
endinterface
`default_nettype wire

### hw/rtl/sorted_list_table_top.sv
// Top level of the sorted list table: a row of compare-and-shift cells.
//
//  port     dir  carries                                   accepted when
//  i_req    in   kind, value                               valid && ready
//  o_rsp    out  status, found, position, entry_count      valid && ready
//
// One request per cycle while i_req.ready is high: all cells compare against the request in parallel and
// shift by one slot in the same cycle; the result goes to an output register.
// The result is registered and is valid in the cycle after the request is accepted.
// i_req.ready drops only while a result waits and o_rsp.ready is low.
// Synchronous reset empties the table (count to zero); entry storage is not cleared.
`default_nettype none
module sorted_list_table_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    slt_req_if.sink     i_req,
    slt_rsp_if.source   o_rsp
);

    localparam int N = slt_pkg::CAPACITY;

    logic [slt_pkg::CNT_W-1:0]          r_count;
    logic [slt_pkg::CNT_W-1:0]          n_count;
    logic                               r_out_valid;
    logic [slt_pkg::STATUS_W-1:0]       r_status;
    logic [slt_pkg::STATUS_W-1:0]       n_status;
    logic                               r_found;
    logic                               n_found;
    logic [slt_pkg::POS_W-1:0]          r_position;
    logic [slt_pkg::POS_W-1:0]          n_position;

    logic                               w_accept;
    logic                               w_full;
    logic                               w_is_ins;
    logic                               w_is_del;
    logic                               w_match_any;
    logic [slt_pkg::IDX_W-1:0]          w_place_idx;
    logic [slt_pkg::IDX_W-1:0]          w_eq_idx;
    slt_pkg::t_cell_ctl                 w_ctl;

    slt_pkg::t_cell_flags               w_flags [N];
    logic signed [slt_pkg::DATA_W-1:0]  w_entry [N];
    logic [N-1:0]                       w_valid;
    logic [N-1:0]                       w_place;
    logic [N-1:0]                       w_first_eq;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == slt_pkg::CNT_W'(N));
    assign w_is_ins    = (i_req.kind == slt_pkg::KIND_INSERT);
    assign w_is_del    = (i_req.kind == slt_pkg::KIND_DELETE);
    assign w_match_any = |w_first_eq;

    assign w_ctl.ins_en = w_accept && w_is_ins && !w_full;
    assign w_ctl.del_en = w_accept && w_is_del && w_match_any;
    assign w_ctl.value  = i_req.value;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            slt_pkg::t_cell_flags               w_left_flags;
            logic signed [slt_pkg::DATA_W-1:0]  w_left_entry;
            logic signed [slt_pkg::DATA_W-1:0]  w_right_entry;

            assign w_valid[g] = (r_count > slt_pkg::CNT_W'(g));

            if (g == 0) begin : g_head
                assign w_left_flags.valid = 1'b1;
                assign w_left_flags.lt    = 1'b0;
                assign w_left_flags.eq    = 1'b0;
                assign w_left_entry       = w_entry[g];
            end else begin : g_body
                assign w_left_flags = w_flags[g-1];
                assign w_left_entry = w_entry[g-1];
            end

            if (g == N - 1) begin : g_tail
                assign w_right_entry = w_entry[g];
            end else begin : g_mid
                assign w_right_entry = w_entry[g+1];
            end

            slt_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_valid       (w_valid[g]),
                .i_left_flags  (w_left_flags),
                .i_left_entry  (w_left_entry),
                .i_right_entry (w_right_entry),
                .o_flags       (w_flags[g]),
                .o_entry       (w_entry[g]),
                .o_place       (w_place[g]),
                .o_first_eq    (w_first_eq[g])
            );
        end
    endgenerate

    // one-hot to index
    always_comb begin
        w_place_idx = '0;
        w_eq_idx    = '0;
        for (int i = 0; i < N; i++) begin
            if (w_place[i]) begin
                w_place_idx = w_place_idx | slt_pkg::IDX_W'(i);
            end
            if (w_first_eq[i]) begin
                w_eq_idx = w_eq_idx | slt_pkg::IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_count    = r_count;
        n_status   = slt_pkg::ST_NOT_FOUND;
        n_found    = 1'b0;
        n_position = '0;
        if (w_is_ins) begin
            if (w_full) begin
                n_status = slt_pkg::ST_FULL;
            end else begin
                n_status   = slt_pkg::ST_DONE;
                n_found    = 1'b1;
                n_position = slt_pkg::POS_W'(w_place_idx);
                n_count    = r_count + slt_pkg::CNT_W'(1);
            end
        end else if (w_match_any) begin
            n_status   = slt_pkg::ST_DONE;
            n_found    = 1'b1;
            n_position = slt_pkg::POS_W'(w_eq_idx);
            if (w_is_del) begin
                n_count = r_count - slt_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= n_status;
            r_found    <= n_found;
            r_position <= n_position;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.found       = r_found;
    assign o_rsp.position    = r_position;
    assign o_rsp.entry_count = slt_pkg::COUNT_W'(r_count);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= slt_pkg::CNT_W'(N))
        else $error("entry count above capacity");

    a_place_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_place))
        else $error("insert slot not unique");

    a_first_eq_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first_eq))
        else $error("first match not unique");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins_en |=> r_count == $past(r_count) + slt_pkg::CNT_W'(1))
        else $error("insert did not grow the table");

    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found) |-> o_rsp.status == slt_pkg::ST_DONE)
        else $error("found result without done status");
`endif

endmodule
`default_nettype wire

### hw/rtl/slt_cell.sv
// One slot of the sorted table: holds an entry, compares it, shifts with neighbors.
`default_nettype none
module slt_cell (
    input  wire logic                                 i_clk,
    input  wire slt_pkg::t_cell_ctl                   i_ctl,
    input  wire logic                                 i_valid,
    input  wire slt_pkg::t_cell_flags                 i_left_flags,
    input  wire logic signed [slt_pkg::DATA_W-1:0]    i_left_entry,
    input  wire logic signed [slt_pkg::DATA_W-1:0]    i_right_entry,
    output slt_pkg::t_cell_flags                      o_flags,
    output logic signed [slt_pkg::DATA_W-1:0]         o_entry,
    output logic                                      o_place,
    output logic                                      o_first_eq
);

    logic signed [slt_pkg::DATA_W-1:0] r_entry;
    logic signed [slt_pkg::DATA_W-1:0] n_entry;
    logic                              w_lt;
    logic                              w_eq;

    assign w_lt = i_valid && (i_ctl.value < r_entry);
    assign w_eq = i_valid && (i_ctl.value == r_entry);

    // Insert lands on the first entry greater than the value, or on the first empty slot.
    assign o_place    = !i_left_flags.lt && (w_lt || (i_left_flags.valid && !i_valid));
    // Equal entries are contiguous, so the first one has no equal left neighbor.
    assign o_first_eq = w_eq && !i_left_flags.eq;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins_en) begin
            if (i_left_flags.lt) begin
                n_entry = i_left_entry;
            end else if (o_place) begin
                n_entry = i_ctl.value;
            end
        end else if (i_ctl.del_en) begin
            // everything at or after the first match moves one slot left
            if (w_eq || w_lt) begin
                n_entry = i_right_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry       = r_entry;
    assign o_flags.valid = i_valid;
    assign o_flags.lt    = w_lt;
    assign o_flags.eq    = w_eq;

endmodule
`default_nettype wire

### verif/slt_checker.sv
`timescale 1ns / 100ps
// Checker for the sorted list table: tracks table contents and compares every result.
module slt_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    slt_req_if        i_req,
    slt_rsp_if        i_rsp,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_full_seen,
    output int        o_miss_seen,
    output int        o_peak_count
);
    import slt_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  entry_count;
    } slt_result_t;

    // Mirror of the stored entries, kept in ascending order.
    logic signed [DATA_W-1:0] table_vals[$];
    slt_result_t              expected_results[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_full_seen  = 0;
        o_miss_seen  = 0;
        o_peak_count = 0;
    end

    task automatic flag_mismatch(input string field, input int got, input int want);
        o_fail_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    endtask

    function automatic slt_result_t predict_table_op(input logic [KIND_W-1:0] kind,
                                                     input logic signed [DATA_W-1:0] value);
        slt_result_t r;
        int          p;
        int          i;
        r        = '0;
        r.status = ST_NOT_FOUND;
        p        = table_vals.size();
        if (kind == KIND_INSERT) begin
            if (table_vals.size() >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // goes after every equal entry
                for (i = 0; i < table_vals.size(); i++) begin
                    if (value < table_vals[i]) begin
                        p = i;
                        break;
                    end
                end
                table_vals.insert(p, value);
                r.status   = ST_DONE;
                r.found    = 1'b1;
                r.position = POS_W'(p);
            end
        end else begin
            // delete, search, and the spare code (acts as search)
            for (i = 0; i < table_vals.size(); i++) begin
                if (table_vals[i] == value) begin
                    p = i;
                    break;
                end
            end
            if (p < table_vals.size()) begin
                r.status   = ST_DONE;
                r.found    = 1'b1;
                r.position = POS_W'(p);
                if (kind == KIND_DELETE)
                    table_vals.delete(p);
            end
        end
        r.entry_count = COUNT_W'(table_vals.size());
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        slt_result_t want;
        if (i_rst_n) begin
            // retire before predicting so a stray result is never matched to a new request
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("result with no request pending", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_rsp.status !== want.status)
                        flag_mismatch("status", i_rsp.status, want.status);
                    if (i_rsp.found !== want.found)
                        flag_mismatch("found", i_rsp.found, want.found);
                    if (i_rsp.position !== want.position)
                        flag_mismatch("position", i_rsp.position, want.position);
                    if (i_rsp.entry_count !== want.entry_count)
                        flag_mismatch("entry_count", i_rsp.entry_count, want.entry_count);
                end
            end
            if (i_req.valid && i_req.ready) begin
                want = predict_table_op(i_req.kind, i_req.value);
                if (want.status == ST_FULL)
                    o_full_seen++;
                if (want.status == ST_NOT_FOUND)
                    o_miss_seen++;
                if (int'(want.entry_count) > o_peak_count)
                    o_peak_count = int'(want.entry_count);
                expected_results.push_back(want);
            end
            o_pending = expected_results.size();
        end
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the sorted list table: clock, reset, request and result traffic, verdict.
module tb_top;
    import slt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1424;
    localparam int CALM_ITEMS   = 150;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_AT     = 900;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic i_clk;
    logic i_rst_n;

    slt_req_if req_ch ();
    slt_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int full_seen;
    int miss_seen;
    int peak_count;
    int sent_count  = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;
    bit long_hold   = 1'b0;

    sorted_list_table_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    slt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_full_seen  (full_seen),
        .o_miss_seen  (miss_seen),
        .o_peak_count (peak_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending", cycle_count, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_request(input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] value);
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.value <= value;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        sent_count++;
    endtask

    // Drop valid and put junk on the payload while idle.
    task automatic idle_sender(input int cycles);
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_W'($urandom);
        req_ch.value <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Mostly a small pool so duplicates and matches are common.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3:       return VAL_MIN;
            4:       return VAL_MAX;
            default: return $urandom_range(0, 12) - 6;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input int insert_pct);
        int r;
        if ($urandom_range(0, 99) < insert_pct)
            return KIND_INSERT;
        r = $urandom_range(0, 19);
        if (r == 0)
            return KIND_SPARE;
        else if (r < 10)
            return KIND_DELETE;
        else
            return KIND_SEARCH;
    endfunction

    // Result side: random stalls, one long hold-off on request, none once calm.
    initial begin : result_side
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    initial begin : request_side
        int n;
        int ins_pct;
        int gapless_left;
        ins_pct      = 50;
        gapless_left = 0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_SEARCH;
        req_ch.value <= '0;
        i_rst_n      <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: misses on search, delete and the spare code
        push_request(KIND_SEARCH, 0);
        push_request(KIND_DELETE, -1);
        push_request(KIND_SPARE, VAL_MAX);
        // extremes and a duplicate
        push_request(KIND_INSERT, VAL_MAX);
        push_request(KIND_INSERT, VAL_MIN);
        push_request(KIND_INSERT, 0);
        push_request(KIND_INSERT, 0);
        push_request(KIND_INSERT, -1);
        push_request(KIND_SEARCH, 0);
        push_request(KIND_SEARCH, VAL_MIN);
        push_request(KIND_SPARE, VAL_MAX);
        push_request(KIND_DELETE, 0);
        push_request(KIND_DELETE, 77);
        // fill up, then one insert too many
        repeat (12) push_request(KIND_INSERT, pick_value());
        push_request(KIND_INSERT, 5);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 4))
                    0:       ins_pct = 15;
                    1:       ins_pct = 35;
                    2:       ins_pct = 50;
                    3:       ins_pct = 65;
                    default: ins_pct = 85;
                endcase
            end
            if (n == HOLD_AT) begin
                // back-to-back requests against a stalled result side
                long_hold    = 1'b1;
                gapless_left = 24;
            end
            if (n == DRAIN_AT) begin
                idle_sender(1);
                wait (pending == 0);
            end
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (gapless_left > 0)
                gapless_left--;
            else if (!calm && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 15));
            push_request(pick_kind(ins_pct), pick_value());
        end

        idle_sender(1);
        wait (pending == 0);
        repeat (5) @(posedge i_clk);

        $display("Sent %0d requests; %0d inserts hit a full table, %0d lookups missed,",
                 sent_count, full_seen, miss_seen);
        $display("table peaked at %0d entries; %0d mismatches.", peak_count, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
